// ===== sv/bsnf_pkg.sv =====
// shared types, constants and helpers of the sweep and prune neighbour finder
package bsnf_pkg;

  localparam int unsigned MAX_BOXES_DEF = 64;
  localparam int unsigned AXIS_STEP     = 5;
  localparam int unsigned LIST_CAP      = 64;
  localparam int unsigned K_W           = 7;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic       CFG_PADDING = 1'b0;
  localparam logic       CFG_THREE_D = 1'b1;
  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
    logic               dyn;
    logic signed [6:0]  par;
    logic signed [6:0]  sib;
  } entry_t;

  typedef enum logic [1:0] {RD_I, RD_J, RD_BOX, RD_ORD} rd_sel_e;
  typedef enum logic [2:0] {PEND_NONE, PEND_SELF, PEND_PAR, PEND_SIB, PEND_IDX} pend_src_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_AX_R0, ST_AX_I0, ST_AX_R, ST_AX_A, ST_AX_FIN,
    ST_SORT_P, ST_SORT_PL, ST_SORT_R, ST_SORT_C, ST_SORT_W,
    ST_Q_R, ST_Q_L, ST_Q_PAR, ST_Q_SIB, ST_Q_ORD, ST_Q_ENT, ST_Q_CMP, ST_Q_FLUSH
  } state_e;

  typedef struct packed {
    rd_sel_e   rd_sel;
    logic      wr_entry;
    logic      load_n;
    logic      i_clr;
    logic      i_one;
    logic      i_inc;
    logic      i_step;
    logic      j_inc;
    logic      ax_init;
    logic      ax_acc;
    logic      ax_fin;
    logic      piv_latch;
    logic      rank_acc;
    logic      ord_wr;
    logic      q_take;
    logic      q_latch;
    logic      s_inc;
    logic      pend_ld;
    pend_src_e pend_src;
    logic      push;
    logic      push_last;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic last;
    logic box_ok;
    logic three_d;
    logic n_gt1;
    logic ax_more;
    logic j_more;
    logic i_more;
    logic q_bad;
    logic par_ok;
    logic sib_ok;
    logic s_done;
    logic k_full;
    logic skip;
    logic below;
    logic beyond;
    logic hit;
    logic out_free;
  } stat_t;

  // lower corner on one axis
  function automatic logic signed [31:0] lo_of(entry_t e, logic [1:0] ax);
    logic signed [31:0] r;
    unique case (ax)
      AXIS_Y:  r = e.lo_y;
      AXIS_Z:  r = e.lo_z;
      default: r = e.lo_x;
    endcase
    return r;
  endfunction

  // upper corner on one axis
  function automatic logic signed [31:0] hi_of(entry_t e, logic [1:0] ax);
    logic signed [31:0] r;
    unique case (ax)
      AXIS_Y:  r = e.hi_y;
      AXIS_Z:  r = e.hi_z;
      default: r = e.hi_x;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bsnf_ctrl.sv =====
// controller state machine: load, axis choice, rank sort and query scan
module bsnf_ctrl
  import bsnf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel   = RD_I;
    cmd_o.pend_src = PEND_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.func == FUNC_QUERY) begin
            cmd_o.q_take = 1'b1;
            state_d = ST_Q_R;
          end else if (stat_i.box_ok) begin
            cmd_o.wr_entry = 1'b1;
            if (stat_i.last) begin
              cmd_o.load_n = 1'b1;
              cmd_o.i_clr  = 1'b1;
              state_d = stat_i.three_d ? ST_AX_R0 : ST_SORT_P;
            end
          end
        end
      end
      // axis choice over boxes 0, 1, 6, 11, ...
      ST_AX_R0: state_d = ST_AX_I0;
      ST_AX_I0: begin
        cmd_o.ax_init = 1'b1;
        cmd_o.i_one   = 1'b1;
        state_d = stat_i.n_gt1 ? ST_AX_R : ST_AX_FIN;
      end
      ST_AX_R: state_d = ST_AX_A;
      ST_AX_A: begin
        cmd_o.ax_acc = 1'b1;
        cmd_o.i_step = 1'b1;
        state_d = stat_i.ax_more ? ST_AX_R : ST_AX_FIN;
      end
      ST_AX_FIN: begin
        cmd_o.ax_fin = 1'b1;
        cmd_o.i_clr  = 1'b1;
        state_d = ST_SORT_P;
      end
      // rank of box i against every box j
      ST_SORT_P: state_d = ST_SORT_PL;
      ST_SORT_PL: begin
        cmd_o.piv_latch = 1'b1;
        state_d = ST_SORT_R;
      end
      ST_SORT_R: begin
        cmd_o.rd_sel = RD_J;
        state_d = ST_SORT_C;
      end
      ST_SORT_C: begin
        cmd_o.rd_sel   = RD_J;
        cmd_o.rank_acc = 1'b1;
        cmd_o.j_inc    = 1'b1;
        state_d = stat_i.j_more ? ST_SORT_R : ST_SORT_W;
      end
      ST_SORT_W: begin
        cmd_o.ord_wr = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d = stat_i.i_more ? ST_SORT_P : ST_IDLE;
      end
      // query: fetch the box itself
      ST_Q_R: begin
        cmd_o.rd_sel = RD_BOX;
        state_d = ST_Q_L;
      end
      ST_Q_L: begin
        cmd_o.rd_sel  = RD_BOX;
        cmd_o.pend_ld = 1'b1;
        if (stat_i.q_bad) begin
          cmd_o.pend_src = PEND_NONE;
          state_d = ST_Q_FLUSH;
        end else begin
          cmd_o.pend_src = PEND_SELF;
          cmd_o.q_latch  = 1'b1;
          state_d = ST_Q_PAR;
        end
      end
      ST_Q_PAR: begin
        if (!stat_i.par_ok) begin
          state_d = ST_Q_SIB;
        end else if (stat_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.pend_ld  = 1'b1;
          cmd_o.pend_src = PEND_PAR;
          state_d = ST_Q_SIB;
        end
      end
      ST_Q_SIB: begin
        if (!stat_i.sib_ok) begin
          state_d = ST_Q_ORD;
        end else if (stat_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.pend_ld  = 1'b1;
          cmd_o.pend_src = PEND_SIB;
          state_d = ST_Q_ORD;
        end
      end
      // sweep over the sorted order
      ST_Q_ORD: state_d = (stat_i.s_done || stat_i.k_full) ? ST_Q_FLUSH : ST_Q_ENT;
      ST_Q_ENT: begin
        cmd_o.rd_sel = RD_ORD;
        state_d = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        cmd_o.rd_sel = RD_ORD;
        if (stat_i.skip || stat_i.below) begin
          cmd_o.s_inc = 1'b1;
          state_d = ST_Q_ORD;
        end else if (stat_i.beyond) begin
          state_d = ST_Q_FLUSH;
        end else if (!stat_i.hit) begin
          cmd_o.s_inc = 1'b1;
          state_d = ST_Q_ORD;
        end else if (stat_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.pend_ld  = 1'b1;
          cmd_o.pend_src = PEND_IDX;
          cmd_o.s_inc    = 1'b1;
          state_d = ST_Q_ORD;
        end
      end
      ST_Q_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/bsnf_dp.sv =====
// datapath: box store, sorted order store, counters, compare logic, output register
module bsnf_dp
  import bsnf_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [215:0] in_data_i,
  input  logic         in_func_i,
  input  logic         in_last_i,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  cmd_t         cmd_i,
  output stat_t        stat_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [5:0]   out_box_o,
  output logic [5:0]   out_nb_o,
  output logic         out_has_o,
  output logic         out_last_o
);

  localparam int unsigned IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned NW = $clog2(MAX_BOXES + 1);
  localparam int unsigned CW = $clog2(MAX_BOXES + AXIS_STEP + 1);

  // input fields
  logic [5:0] in_box;
  entry_t     in_entry;
  assign in_box         = in_data_i[5:0];
  assign in_entry.lo_x  = in_data_i[37:6];
  assign in_entry.lo_y  = in_data_i[69:38];
  assign in_entry.lo_z  = in_data_i[101:70];
  assign in_entry.hi_x  = in_data_i[133:102];
  assign in_entry.hi_y  = in_data_i[165:134];
  assign in_entry.hi_z  = in_data_i[197:166];
  assign in_entry.dyn   = in_data_i[198];
  assign in_entry.par   = in_data_i[205:199];
  assign in_entry.sib   = in_data_i[212:206];

  // configuration registers
  logic [30:0] pad_q;
  logic        three_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q     <= '0;
      three_d_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PADDING: pad_q     <= cfg_data_i[30:0];
        CFG_THREE_D: three_d_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control registers
  logic [NW-1:0] n_q;
  logic [1:0]    axis_q;
  logic [CW-1:0] i_q, j_q, s_q;
  logic [IW-1:0] rank_q;
  logic [K_W-1:0] k_q;
  logic [5:0]    q_box_q;

  // memories
  entry_t        ent_mem [MAX_BOXES];
  logic [IW-1:0] ord_mem [MAX_BOXES];
  entry_t        ent_q;
  logic [IW-1:0] ord_q;
  logic [IW-1:0] ent_raddr;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_J:    ent_raddr = j_q[IW-1:0];
      RD_BOX:  ent_raddr = q_box_q[IW-1:0];
      RD_ORD:  ent_raddr = ord_q;
      default: ent_raddr = i_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) ent_mem[in_box[IW-1:0]] <= in_entry;
    ent_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_wr) ord_mem[rank_q] <= i_q[IW-1:0];
    ord_q <= ord_mem[s_q[IW-1:0]];
  end

  // axis choice accumulators
  logic signed [31:0] mlo_x_q, mlo_y_q, mlo_z_q, mhi_x_q, mhi_y_q, mhi_z_q;
  logic signed [33:0] ext_x, ext_y, ext_z;
  logic [1:0]         ax_pick;
  assign ext_x = 34'(mhi_x_q) - 34'(mlo_x_q);
  assign ext_y = 34'(mhi_y_q) - 34'(mlo_y_q);
  assign ext_z = 34'(mhi_z_q) - 34'(mlo_z_q);
  always_comb begin
    ax_pick = (ext_y > ext_x) ? AXIS_Y : AXIS_X;
    if (ext_z > ((ax_pick == AXIS_Y) ? ext_y : ext_x)) ax_pick = AXIS_Z;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ax_init) begin
      mlo_x_q <= ent_q.lo_x; mlo_y_q <= ent_q.lo_y; mlo_z_q <= ent_q.lo_z;
      mhi_x_q <= ent_q.hi_x; mhi_y_q <= ent_q.hi_y; mhi_z_q <= ent_q.hi_z;
    end else if (cmd_i.ax_acc) begin
      if (ent_q.lo_x < mlo_x_q) mlo_x_q <= ent_q.lo_x;
      if (ent_q.lo_y < mlo_y_q) mlo_y_q <= ent_q.lo_y;
      if (ent_q.lo_z < mlo_z_q) mlo_z_q <= ent_q.lo_z;
      if (ent_q.hi_x > mhi_x_q) mhi_x_q <= ent_q.hi_x;
      if (ent_q.hi_y > mhi_y_q) mhi_y_q <= ent_q.hi_y;
      if (ent_q.hi_z > mhi_z_q) mhi_z_q <= ent_q.hi_z;
    end
  end

  // rank sort pivot and comparison
  logic signed [31:0] piv_q;
  logic signed [31:0] ent_lo_ax, ent_hi_ax;
  logic               before_piv;
  assign ent_lo_ax  = lo_of(ent_q, axis_q);
  assign ent_hi_ax  = hi_of(ent_q, axis_q);
  assign before_piv = (ent_lo_ax < piv_q) || ((ent_lo_ax == piv_q) && (j_q < i_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.piv_latch) piv_q <= ent_lo_ax;
  end

  // counters, box count and sweep axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      axis_q  <= AXIS_X;
      i_q     <= '0;
      j_q     <= '0;
      s_q     <= '0;
      rank_q  <= '0;
      k_q     <= '0;
      q_box_q <= '0;
    end else begin
      if (cmd_i.load_n) begin
        n_q    <= NW'(in_box[IW-1:0]) + NW'(1);
        axis_q <= AXIS_X;
      end
      if (cmd_i.ax_fin) axis_q <= ax_pick;
      if (cmd_i.i_clr)       i_q <= '0;
      else if (cmd_i.i_one)  i_q <= CW'(1);
      else if (cmd_i.i_step) i_q <= i_q + CW'(AXIS_STEP);
      else if (cmd_i.i_inc)  i_q <= i_q + CW'(1);
      if (cmd_i.piv_latch) begin
        j_q    <= '0;
        rank_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CW'(1);
        if (cmd_i.rank_acc && before_piv) rank_q <= rank_q + IW'(1);
      end
      if (cmd_i.q_take) q_box_q <= in_box;
      if (cmd_i.q_latch) begin
        s_q <= '0;
        k_q <= K_W'(1);
      end else begin
        if (cmd_i.s_inc) s_q <= s_q + CW'(1);
        if (cmd_i.push && !cmd_i.push_last) k_q <= k_q + K_W'(1);
      end
    end
  end

  // padded bounds of the queried box
  logic signed [33:0] plo_x_q, plo_y_q, plo_z_q, phi_x_q, phi_y_q, phi_z_q;
  logic signed [33:0] pad_s;
  logic signed [6:0]  par_q, sib_q;
  assign pad_s = $signed(34'(pad_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_latch) begin
      plo_x_q <= 34'(ent_q.lo_x) - pad_s;
      plo_y_q <= 34'(ent_q.lo_y) - pad_s;
      plo_z_q <= 34'(ent_q.lo_z) - pad_s;
      phi_x_q <= 34'(ent_q.hi_x) + pad_s;
      phi_y_q <= 34'(ent_q.hi_y) + pad_s;
      phi_z_q <= 34'(ent_q.hi_z) + pad_s;
      par_q   <= ent_q.par;
      sib_q   <= ent_q.sib;
    end
  end

  // scan candidate tests
  logic signed [33:0] plo_ax, phi_ax;
  logic [5:0]         cand;
  logic               ov_x, ov_y, ov_z;
  always_comb begin
    unique case (axis_q)
      AXIS_Y:  begin plo_ax = plo_y_q; phi_ax = phi_y_q; end
      AXIS_Z:  begin plo_ax = plo_z_q; phi_ax = phi_z_q; end
      default: begin plo_ax = plo_x_q; phi_ax = phi_x_q; end
    endcase
  end
  assign cand = 6'(ord_q);
  assign ov_x = !(plo_x_q > 34'(ent_q.hi_x)) && !(phi_x_q < 34'(ent_q.lo_x));
  assign ov_y = !(plo_y_q > 34'(ent_q.hi_y)) && !(phi_y_q < 34'(ent_q.lo_y));
  assign ov_z = !(plo_z_q > 34'(ent_q.hi_z)) && !(phi_z_q < 34'(ent_q.lo_z));

  // pending result, held until the next one proves it is not the last
  logic [5:0] pend_idx_q;
  logic       pend_has_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_ld) begin
      unique case (cmd_i.pend_src)
        PEND_SELF: begin pend_idx_q <= q_box_q;            pend_has_q <= 1'b1; end
        PEND_PAR:  begin pend_idx_q <= par_q[5:0];         pend_has_q <= 1'b1; end
        PEND_SIB:  begin pend_idx_q <= sib_q[5:0];         pend_has_q <= 1'b1; end
        PEND_IDX:  begin pend_idx_q <= cand;               pend_has_q <= 1'b1; end
        default:   begin pend_idx_q <= '0;                 pend_has_q <= 1'b0; end
      endcase
    end
  end

  // output register
  logic       out_valid_q;
  logic [5:0] out_box_q, out_nb_q;
  logic       out_has_q, out_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                  out_valid_q <= 1'b0;
    else if (cmd_i.push)          out_valid_q <= 1'b1;
    else if (out_ready_i)         out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_box_q  <= q_box_q;
      out_nb_q   <= pend_idx_q;
      out_has_q  <= pend_has_q;
      out_last_q <= cmd_i.push_last;
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_box_o   = out_box_q;
  assign out_nb_o    = out_nb_q;
  assign out_has_o   = out_has_q;
  assign out_last_o  = out_last_q;

  // status towards the controller
  assign stat_o.func     = in_func_i;
  assign stat_o.last     = in_last_i;
  assign stat_o.box_ok   = (7'(in_box) < 7'(MAX_BOXES));
  assign stat_o.three_d  = three_d_q;
  assign stat_o.n_gt1    = (n_q > NW'(1));
  assign stat_o.ax_more  = ((i_q + CW'(AXIS_STEP)) < CW'(n_q));
  assign stat_o.j_more   = ((j_q + CW'(1)) < CW'(n_q));
  assign stat_o.i_more   = ((i_q + CW'(1)) < CW'(n_q));
  assign stat_o.q_bad    = (7'(q_box_q) >= 7'(n_q)) || !ent_q.dyn;
  assign stat_o.par_ok   = !par_q[6];
  assign stat_o.sib_ok   = !sib_q[6];
  assign stat_o.s_done   = (s_q >= CW'(n_q));
  assign stat_o.k_full   = (k_q >= K_W'(LIST_CAP));
  assign stat_o.skip     = (cand == q_box_q) || ($signed({1'b0, cand}) == par_q) ||
                           ($signed({1'b0, cand}) == sib_q);
  assign stat_o.below    = (34'(ent_hi_ax) < plo_ax);
  assign stat_o.beyond   = (34'(ent_lo_ax) > phi_ax);
  assign stat_o.hit      = ov_x && ov_y && ov_z;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== sv/box_sweep_neighbor_finder_core.sv =====
// top level of the sweep and prune neighbour finder
// Input stream: tuser is func (0 load a box, 1 query its list), tlast marks
// the final load, tdata carries the box fields. Loads are written to the box
// store as they are taken. The final load then picks the sweep axis over
// boxes 0,1,6,11,... (in three_d_mode; else the axis is X) and ranks every
// box against every other; no input transfer is taken meanwhile.
// A query first fetches its box, then gives one result each for self and
// for a valid parent and sibling, then scans the sorted order, reading each
// entry's index and then its box through the single read port of the box
// store.
// Results leave through a one-item output register and a pending register,
// so the search goes on while the receiver stalls until a third is found.
// A static or unknown box gives one result with has_neighbor 0.
// Reset clears the box count, sweep axis, configuration and output valid;
// the box and order stores hold no reset value until loaded.
// The configuration channel is always ready; write it only while idle.
module box_sweep_neighbor_finder_core
  import bsnf_pkg::*;
#(
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // box_index[5:0], min_x, min_y, min_z, max_x, max_y, max_z, is_dynamic,
  // parent_index[6:0], sibling_index[6:0], zero fill
  input  logic [215:0] s_axis_tdata_i,
  // func
  input  logic         s_axis_tuser_i,
  // last_load
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // queried_box[5:0], neighbor_index[11:6], zero fill
  output logic [15:0]  m_axis_tdata_o,
  // has_neighbor
  output logic         m_axis_tuser_o,
  // last_of_list
  output logic         m_axis_tlast_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  cmd_t       cmd;
  stat_t      stat;
  logic [5:0] out_box, out_nb;

  assign cfg_ready_o = 1'b1;

  // sequencer
  bsnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores and compare logic
  bsnf_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_func_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_box_o   (out_box),
    .out_nb_o    (out_nb),
    .out_has_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, out_nb, out_box};

endmodule
